/* rtl/core/bed_pkg.sv */
`default_nettype none

package bed_pkg;

    // Size limits of the window and of the line storage.
    localparam int MAX_RADIUS   = 7;
    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int SPAN         = 2 * MAX_RADIUS + 1;
    localparam int SLOT_W       = $clog2(SPAN);
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
    localparam int IDX_W        = COL_W + ROW_W;

    // Depth of the queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QLW    = QPW + 1;

    // Configuration port.
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // Item codes and pixel levels.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;
    localparam logic [7:0] PIX_FG = 8'd255;
    localparam logic [7:0] PIX_BG = 8'd0;

    typedef struct packed {
        logic       opcode;
        logic [7:0] pixel_in;
    } pix_item_t;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       last_in_frame;
    } res_item_t;

    // Effective configuration seen by the datapath.
    typedef struct packed {
        logic [2:0]  radius;
        logic [10:0] w_eff;
        logic [12:0] h_eff;
        logic [22:0] total;
        logic [13:0] lag;
    } cfg_t;

    typedef logic [SPAN-1:0] col_t;
    // Window indexed [column offset][row offset], offset 0 is the newest.
    typedef logic [SPAN-1:0][SPAN-1:0] win_t;

    // Work handed from the front to the back.
    typedef struct packed {
        logic shift;
        col_t col;
        logic emit;
        logic border;
        logic last;
    } job_t;

    // Disc of the given radius in window coordinates.
    function automatic win_t disc_mask(input logic [2:0] r);
        win_t m;
        int   ri;
        ri = int'(r);
        m = '0;
        for (int d = 0; d < SPAN; d++)
        begin
            for (int e = 0; e < SPAN; e++)
            begin
                if (d <= 2 * ri && e <= 2 * ri &&
                    (d - ri) * (d - ri) + (e - ri) * (e - ri) <= ri * ri)
                begin
                    m[e][d] = 1'b1;
                end
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/bed_cfg.sv */
`default_nettype none

module bed_cfg
    import bed_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output cfg_t                   cfg,
    output logic                   cfg_wr
);

    logic [2:0]  radius_reg;
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic        wr_en;
    logic [23:0] prod;
    logic [13:0] rw;

    assign wr_en = psel && penable && pwrite;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 3'd1;
            width_reg  <= 11'd1024;
            height_reg <= 13'd1024;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_RADIUS: radius_reg <= pwdata[2:0];
                REG_WIDTH:  width_reg  <= pwdata[10:0];
                REG_HEIGHT: height_reg <= pwdata[12:0];
                default:    ;
            endcase
        end
    end

    // A write to any real register restarts the frame.
    assign cfg_wr = wr_en && (paddr[3:2] == REG_RADIUS || paddr[3:2] == REG_WIDTH ||
                              paddr[3:2] == REG_HEIGHT);

    // Read back.
    always_comb
    begin
        case (paddr[3:2])
            REG_RADIUS: prdata = {29'd0, radius_reg};
            REG_WIDTH:  prdata = {21'd0, width_reg};
            REG_HEIGHT: prdata = {19'd0, height_reg};
            default:    prdata = '0;
        endcase
    end

    // Effective sizes with zero and overrange values clamped, and the derived counts.
    always_comb
    begin
        cfg.radius = radius_reg;
        if (width_reg == 11'd0)
            cfg.w_eff = 11'd1;
        else if (width_reg > 11'(MAX_WIDTH))
            cfg.w_eff = 11'(MAX_WIDTH);
        else
            cfg.w_eff = width_reg;
        if (height_reg == 13'd0)
            cfg.h_eff = 13'd1;
        else if (height_reg > 13'(HEIGHT_LIMIT))
            cfg.h_eff = 13'(HEIGHT_LIMIT);
        else
            cfg.h_eff = height_reg;
        prod      = {13'd0, cfg.w_eff} * {11'd0, cfg.h_eff};
        cfg.total = prod[22:0];
        rw        = {11'd0, radius_reg} * {3'd0, cfg.w_eff};
        cfg.lag   = rw + {11'd0, radius_reg};
    end

endmodule

`default_nettype wire

/* rtl/core/bed_front.sv */
`default_nettype none

module bed_front
    import bed_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire cfg_t           cfg,
    input  wire logic           cfg_wr,
    input  wire logic           pix_valid,
    output logic                pix_ready,
    input  wire pix_item_t      pix_item,
    input  wire logic [QLW-1:0] q_level,
    output logic                q_push,
    output job_t                q_entry
);

    typedef struct packed {
        logic              shift;
        logic              newbit;
        logic [SLOT_W-1:0] slot;
        logic              emit;
        logic              border;
        logic              last;
    } s1_t;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [IDX_W-1:0]  n_reg, n_next;
    logic              done_reg, done_next;
    logic [IDX_W-1:0]  oidx_reg, oidx_next;
    logic [ROW_W-1:0]  oi_reg, oi_next;
    logic [COL_W-1:0]  oj_reg, oj_next;
    logic              s1_valid_reg;
    s1_t               s1_reg;
    col_t              rd_reg;
    col_t              row_mem [MAX_WIDTH];

    logic accept, is_pix, fg, emit, last, border;

    // Room is kept for the item still in the read stage.
    assign pix_ready = (q_level + {{(QLW-1){1'b0}}, s1_valid_reg}) < QLW'(QDEPTH);
    assign accept    = pix_valid && pix_ready;
    assign is_pix    = accept && pix_item.opcode == OP_PIXEL && !done_reg;
    assign fg        = pix_item.pixel_in == PIX_FG;

    // A pixel emits once the lag is filled; other items emit only after the frame's input.
    assign emit = (is_pix && n_reg >= IDX_W'(cfg.lag)) || (accept && !is_pix && done_reg);
    assign last = emit && ({1'b0, oidx_reg} == cfg.total - 23'd1);

    assign border = (oi_reg < ROW_W'(cfg.radius)) ||
                    ({1'b0, oi_reg} + 13'(cfg.radius) >= cfg.h_eff) ||
                    (oj_reg < COL_W'(cfg.radius)) ||
                    ({1'b0, oj_reg} + 11'(cfg.radius) >= cfg.w_eff);

    // Frame counters.
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        n_next    = n_reg;
        done_next = done_reg;
        oidx_next = oidx_reg;
        oi_next   = oi_reg;
        oj_next   = oj_reg;
        if (is_pix)
        begin
            n_next = n_reg + IDX_W'(1);
            if ({1'b0, col_reg} + 11'd1 >= cfg.w_eff)
            begin
                col_next  = '0;
                row_next  = row_reg + ROW_W'(1);
                slot_next = (slot_reg == SLOT_W'(SPAN - 1)) ? '0 : slot_reg + SLOT_W'(1);
                if ({1'b0, row_reg} + 13'd1 >= cfg.h_eff)
                begin
                    done_next = 1'b1;
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
        if (emit)
        begin
            oidx_next = oidx_reg + IDX_W'(1);
            if ({1'b0, oj_reg} + 11'd1 >= cfg.w_eff)
            begin
                oj_next = '0;
                oi_next = oi_reg + ROW_W'(1);
            end
            else
            begin
                oj_next = oj_reg + COL_W'(1);
            end
        end
        if (cfg_wr || last)
        begin
            col_next  = '0;
            row_next  = '0;
            slot_next = '0;
            n_next    = '0;
            done_next = 1'b0;
            oidx_next = '0;
            oi_next   = '0;
            oj_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            slot_reg     <= '0;
            n_reg        <= '0;
            done_reg     <= 1'b0;
            oidx_reg     <= '0;
            oi_reg       <= '0;
            oj_reg       <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            slot_reg     <= slot_next;
            n_reg        <= n_next;
            done_reg     <= done_next;
            oidx_reg     <= oidx_next;
            oi_reg       <= oi_next;
            oj_reg       <= oj_next;
            s1_valid_reg <= accept;
        end
    end

    // Read stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.shift  <= is_pix;
            s1_reg.newbit <= fg;
            s1_reg.slot   <= slot_reg;
            s1_reg.emit   <= emit;
            s1_reg.border <= border;
            s1_reg.last   <= last;
        end
    end

    // Line storage: one bit per stored row at each column, written one row bit at a time.
    always_ff @(posedge clk)
    begin
        if (is_pix)
        begin
            row_mem[col_reg][slot_reg] <= fg;
        end
        if (accept)
        begin
            rd_reg <= row_mem[col_reg];
        end
    end

    // Build the queue entry, with the column in row-offset order, the current row first.
    always_comb
    begin
        logic [SLOT_W:0] sidx;
        sidx = '0;
        q_entry.col = '0;
        for (int d = 0; d < SPAN; d++)
        begin
            if (d == 0)
            begin
                q_entry.col[d] = s1_reg.newbit;
            end
            else
            begin
                sidx = {1'b0, s1_reg.slot} + (SLOT_W+1)'(SPAN - d);
                if (sidx >= (SLOT_W+1)'(SPAN))
                    sidx = sidx - (SLOT_W+1)'(SPAN);
                q_entry.col[d] = rd_reg[sidx[SLOT_W-1:0]];
            end
        end
        q_entry.shift  = s1_reg.shift;
        q_entry.emit   = s1_reg.emit;
        q_entry.border = s1_reg.border;
        q_entry.last   = s1_reg.last;
    end

    assign q_push = s1_valid_reg;

endmodule

`default_nettype wire

/* rtl/core/bed_queue.sv */
`default_nettype none

module bed_queue
    import bed_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire job_t           push_entry,
    input  wire logic           pop,
    output logic                nonempty,
    output job_t                head,
    output logic [QLW-1:0]      level
);

    job_t            slots_reg [QDEPTH];
    logic [QPW-1:0]  wr_ptr_reg;
    logic [QPW-1:0]  rd_ptr_reg;
    logic [QLW-1:0]  cnt_reg;

    assign nonempty = cnt_reg != '0;
    assign head     = slots_reg[rd_ptr_reg];
    assign level    = cnt_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPW'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + QLW'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - QLW'(1);
        end
    end

endmodule

`default_nettype wire

/* rtl/core/bed_back.sv */
`default_nettype none

module bed_back
    import bed_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [2:0] radius,
    input  wire logic       q_nonempty,
    input  wire job_t       q_head,
    output logic            q_pop,
    output logic            res_valid,
    input  wire logic       res_ready,
    output res_item_t       res_item
);

    win_t      win_reg;
    win_t      win_next;
    win_t      mask;
    logic      ov_reg;
    res_item_t res_reg;
    logic      hit;

    assign q_pop = q_nonempty && (!ov_reg || res_ready);
    assign mask  = disc_mask(radius);

    // Every written pixel shifts its column into the window.
    assign win_next = q_head.shift ? {win_reg[SPAN-2:0], q_head.col} : win_reg;
    assign hit      = &(~mask | win_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            if (q_pop)
                win_reg <= win_next;
            if (q_pop && q_head.emit)
                ov_reg <= 1'b1;
            else if (res_ready)
                ov_reg <= 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (q_pop && q_head.emit)
        begin
            res_reg.pixel_out     <= (!q_head.border && hit) ? PIX_FG : PIX_BG;
            res_reg.last_in_frame <= q_head.last;
        end
    end

    assign res_valid = ov_reg;
    assign res_item  = res_reg;

endmodule

`default_nettype wire

/* rtl/core/binary_erosion_disc.sv */
// Binary erosion of a raster-order pixel stream with a disc of radius 0 to 7.
// Input channel pix_valid/pix_ready carries one item per transfer: a pixel
// (opcode 0) or a drain request (opcode 1). Result channel res_valid/res_ready
// gives zero or one eroded pixel (0 or 255) per input item, last_in_frame set
// on the frame's final output. Results lag the pixels by radius rows plus
// radius pixels; after the frame's last pixel, drain items flush the border.
// Registers on the APB port: radius at 0x0, width at 0x4, height at 0x8.
// A write restarts the frame; stored lines are kept.
// Throughput is one item per clock while pix_ready is high, set by the
// registered line store read (one 15-bit word per column) and the window AND
// in the back end. Items pass the read stage, the queue and the output register.
// The four-entry queue between the front and the back absorbs receiver
// stalls; pix_ready drops when the queue cannot take the item in flight.
// Reset restores radius 1 and a 1024 x 1024 frame and empties the pipeline;
// the line store is not cleared and no clearing pass is needed, since
// border outputs never read unwritten lines.
`default_nettype none

module binary_erosion_disc
    import bed_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              pix_valid,
    output logic                   pix_ready,
    input  wire pix_item_t         pix_item,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output res_item_t              res_item,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    cfg_t           cfg;
    logic           cfg_wr;
    logic           q_push;
    job_t           q_entry;
    logic           q_pop;
    logic           q_nonempty;
    job_t           q_head;
    logic [QLW-1:0] q_level;

    assign pready = 1'b1;

    bed_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg),
        .cfg_wr  (cfg_wr)
    );

    bed_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_wr    (cfg_wr),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_item  (pix_item),
        .q_level   (q_level),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    bed_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .nonempty   (q_nonempty),
        .head       (q_head),
        .level      (q_level)
    );

    bed_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .radius     (cfg.radius),
        .q_nonempty (q_nonempty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_item   (res_item)
    );

endmodule

`default_nettype wire

/* rtl/core/bed_checker.sv */
`default_nettype none

module bed_checker
    import bed_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              res_valid,
    input wire logic              res_ready,
    input wire res_item_t         res_item,
    input wire logic              psel,
    input wire logic              penable,
    input wire logic              pwrite,
    input wire logic [ADDR_W-1:0] paddr,
    input wire logic [31:0]       pwdata,
    input wire logic [31:0]       prdata
);

    // A stalled result holds.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_item))
        else $error("result changed while stalled");

    // Eroded pixels are binary.
    a_res_binary: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_item.pixel_out == PIX_FG || res_item.pixel_out == PIX_BG))
        else $error("result pixel not binary");

    // A radius write reads back in the next cycle.
    a_radius_rb: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && paddr[3:2] == REG_RADIUS) ##1
        (psel && paddr[3:2] == REG_RADIUS) |-> prdata[2:0] == $past(pwdata[2:0]))
        else $error("radius readback mismatch");

    // A width write reads back in the next cycle.
    a_width_rb: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && paddr[3:2] == REG_WIDTH) ##1
        (psel && paddr[3:2] == REG_WIDTH) |-> prdata[10:0] == $past(pwdata[10:0]))
        else $error("width readback mismatch");

endmodule

bind binary_erosion_disc bed_checker u_bed_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);

`default_nettype wire

/* verif/binary_erosion_disc_test.sv */
`timescale 1ns / 1ps

module binary_erosion_disc_test;
    import bed_pkg::*;

    // Erosion predictor and store of expected eroded pixels.
    class erosion_scoreboard;
        bit          fg_lines[SPAN * MAX_WIDTH];
        bit          disc[SPAN][SPAN];
        bit [2:0]    radius_reg;
        bit [10:0]   width_reg;
        bit [12:0]   height_reg;
        int          in_col;
        int          in_row;
        int          out_idx;
        bit          frame_in_done;
        res_item_t   expected[$];
        int          errors;
        int          checked;
        int          fg_results;

        function void reset_state();
            foreach (fg_lines[i])
                fg_lines[i] = 1'b0;
            radius_reg = 3'd1;
            width_reg  = 11'd1024;
            height_reg = 13'd1024;
            rebuild();
        endfunction

        function int eff_r();
            return (radius_reg > MAX_RADIUS) ? MAX_RADIUS : int'(radius_reg);
        endfunction

        function int eff_w();
            if (width_reg == 0)
                return 1;
            return (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
        endfunction

        function int eff_h();
            if (height_reg == 0)
                return 1;
            return (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : int'(height_reg);
        endfunction

        // New disc for the current radius; the frame starts over.
        function void rebuild();
            int r;
            r = eff_r();
            for (int a = 0; a < SPAN; a++)
            begin
                for (int b = 0; b < SPAN; b++)
                begin
                    disc[a][b] = (a <= 2 * r && b <= 2 * r &&
                        (a - r) * (a - r) + (b - r) * (b - r) <= r * r);
                end
            end
            in_col = 0;
            in_row = 0;
            out_idx = 0;
            frame_in_done = 1'b0;
        endfunction

        function void configure(logic [1:0] idx, int value);
            case (idx)
                REG_RADIUS: radius_reg = value[2:0];
                REG_WIDTH:  width_reg  = value[10:0];
                REG_HEIGHT: height_reg = value[12:0];
                default: ;
            endcase
            rebuild();
        endfunction

        function logic [7:0] eroded_pixel(int k);
            int w;
            int h;
            int r;
            int i;
            int j;
            w = eff_w();
            h = eff_h();
            r = eff_r();
            i = k / w;
            j = k % w;
            if (i < r || i + r >= h || j < r || j + r >= w)
                return PIX_BG;
            for (int a = 0; a <= 2 * r; a++)
            begin
                for (int b = 0; b <= 2 * r; b++)
                begin
                    if (disc[a][b] &&
                        !fg_lines[((i + a - r) % SPAN) * MAX_WIDTH + j + b - r])
                        return PIX_BG;
                end
            end
            return PIX_FG;
        endfunction

        // Called for every accepted input item.
        function void note_input(pix_item_t it);
            int        w;
            int        total;
            int        n;
            bit        emit;
            res_item_t res;
            w = eff_w();
            total = w * eff_h();
            if (it.opcode == OP_PIXEL && !frame_in_done)
            begin
                n = in_row * w + in_col;
                fg_lines[(in_row % SPAN) * MAX_WIDTH + in_col] = (it.pixel_in == PIX_FG);
                in_col++;
                if (in_col >= w)
                begin
                    in_col = 0;
                    in_row++;
                    if (in_row >= eff_h())
                        frame_in_done = 1'b1;
                end
                emit = (out_idx < total && out_idx + eff_r() * w + eff_r() <= n);
            end
            else
            begin
                emit = (frame_in_done && out_idx < total);
            end
            if (emit)
            begin
                res.pixel_out = eroded_pixel(out_idx);
                res.last_in_frame = (out_idx == total - 1);
                expected.push_back(res);
                out_idx++;
                if (out_idx >= total)
                begin
                    in_col = 0;
                    in_row = 0;
                    out_idx = 0;
                    frame_in_done = 1'b0;
                end
            end
        endfunction

        // Called for every accepted result.
        function void check_result(res_item_t got);
            res_item_t want;
            checked++;
            if (expected.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result pixel=%0d last=%0b",
                             got.pixel_out, got.last_in_frame);
                return;
            end
            want = expected.pop_front();
            if (want.pixel_out == PIX_FG)
                fg_results++;
            if (got.pixel_out !== want.pixel_out ||
                got.last_in_frame !== want.last_in_frame)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result %0d expected pixel=%0d last=%0b, got pixel=%0d last=%0b",
                             checked, want.pixel_out, want.last_in_frame,
                             got.pixel_out, got.last_in_frame);
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              pix_valid;
    logic              pix_ready;
    pix_item_t         pix_item;
    logic              res_valid;
    logic              res_ready;
    res_item_t         res_item;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    erosion_scoreboard sb;
    int                gap_pct;
    int                stall_pct;
    int                items_sent;
    int                frames_done;

    binary_erosion_disc u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_item  (pix_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard limit on the run.
    initial
    begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Result side: check each accepted result, then choose the next stall.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && res_ready)
                sb.check_result(res_item);
            res_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Send one item, with random idle cycles ahead of it.
    task automatic send_item(input logic op, input logic [7:0] pix);
        pix_item_t it;
        it.opcode = op;
        it.pixel_in = pix;
        while ($urandom_range(99) < gap_pct)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_item <= it;
        do
            @(posedge clk);
        while (!pix_ready);
        sb.note_input(it);
        items_sent++;
    endtask

    // Hold the sender until every expected result has come and the pipe is empty.
    task automatic wait_quiet();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.configure(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_frame(input int r, input int w, input int h);
        wait_quiet();
        write_reg(REG_RADIUS, r);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    // One frame of pixels, foreground at the given percentage, then drains until the frame closes.
    // A limit below the frame size leaves the frame unfinished.
    task automatic run_frame(input int fg_pct, input int noise_pct, input int limit);
        int npix;
        npix = sb.eff_w() * sb.eff_h();
        if (limit < npix)
            npix = limit;
        for (int k = 0; k < npix; k++)
        begin
            if ($urandom_range(99) < noise_pct)
                send_item(OP_DRAIN, 8'($urandom));
            if ($urandom_range(99) < fg_pct)
                send_item(OP_PIXEL, PIX_FG);
            else
                send_item(OP_PIXEL, 8'($urandom));
        end
        while (sb.frame_in_done)
        begin
            if ($urandom_range(99) < noise_pct)
                send_item(OP_PIXEL, 8'($urandom));
            else
                send_item(OP_DRAIN, 8'($urandom));
        end
        frames_done++;
    endtask

    task automatic pick_idling(input int mode);
        case (mode % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 61; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 61; end
            default: begin gap_pct = 34; stall_pct = 34; end
        endcase
    endtask

    initial
    begin
        sb = new();
        sb.reset_state();
        rst_n = 1'b0;
        pix_valid = 1'b0;
        pix_item = '0;
        res_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        gap_pct = 0;
        stall_pct = 0;
        items_sent = 0;
        frames_done = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset radius with a tiny frame, pixel levels at the extremes,
        // an early drain and a pixel after the frame's last pixel.
        write_reg(REG_WIDTH, 4);
        write_reg(REG_HEIGHT, 3);
        send_item(OP_DRAIN, 8'hFF);
        for (int k = 0; k < 12; k++)
            send_item(OP_PIXEL, (k == 3) ? 8'd254 : ((k == 9) ? 8'd0 : PIX_FG));
        send_item(OP_PIXEL, 8'hAA);
        while (sb.frame_in_done)
            send_item(OP_DRAIN, 8'h55);

        // Largest disc with exactly one interior pixel, and zero sizes.
        set_frame(7, 15, 15);
        run_frame(100, 0, 1 << 30);
        set_frame(0, 0, 0);
        run_frame(50, 0, 1 << 30);
        set_frame(2, 3, 3);
        run_frame(100, 0, 1 << 30);

        // Saturating sizes: only the start of such a frame is sent.
        set_frame(3, 2047, 8191);
        run_frame(90, 5, 40);
        set_frame(0, 1, 4096);
        run_frame(70, 5, 40);
        set_frame(2, 1024, 2);
        run_frame(90, 5, 40);

        // Random frames, mostly well-formed with foreground-heavy content.
        while (items_sent < 1850)
        begin
            pick_idling(frames_done);
            set_frame($urandom_range(0, 7),
                      ($urandom_range(9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 20),
                      $urandom_range(1, 18));
            run_frame($urandom_range(70, 100), ($urandom_range(3) == 0) ? 8 : 0, 1 << 30);
        end

        // Wind down and report.
        pix_valid <= 1'b0;
        while (sb.expected.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Sent %0d items over %0d frames; checked %0d results, %0d of them foreground.",
                 items_sent, frames_done, sb.checked, sb.fg_results);
        if (sb.errors > 10)
            $display("%0d mismatches in total.", sb.errors);
        if (sb.errors == 0 && sb.expected.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/bed_pkg.sv
rtl/core/bed_cfg.sv
rtl/core/bed_front.sv
rtl/core/bed_queue.sv
rtl/core/bed_back.sv
rtl/core/binary_erosion_disc.sv
rtl/core/bed_checker.sv
verif/binary_erosion_disc_test.sv
